// ===== src/ptbq_pkg.sv =====
// Shared constants, command codes and ring control types for the timer bank.
package ptbq_pkg;

	// Bank and ring sizes
	localparam int TIMERS      = 8;
	localparam int QUEUE_DEPTH = 16;

	// Field widths
	localparam int KIND_W   = 3;
	localparam int ID_W     = 4;
	localparam int PERIOD_W = 16;

	// Derived widths
	localparam int SLOT_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int WALK_W = $clog2(TIMERS + 1);
	localparam int RING_W = $clog2(QUEUE_DEPTH);

	// Command codes
	localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CREATE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_START  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_STOP   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_PERIOD = 3'd4;
	localparam logic [KIND_W-1:0] KIND_POP    = 3'd5;
	localparam logic [KIND_W-1:0] KIND_TAKE   = 3'd6;

	// Status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	localparam logic [PERIOD_W-1:0] COUNT_MAX = 16'hFFFF;

	// Requests into the event ring
	typedef struct packed {
		logic            push;
		logic [ID_W-1:0] push_id;
		logic            pop;
	} ring_ctl_t;

	// Ring status back to the sequencer
	typedef struct packed {
		logic            empty;
		logic [ID_W-1:0] rd_data;
	} ring_sts_t;

	// Ring pointer advance with wrap at QUEUE_DEPTH
	function automatic logic [RING_W-1:0] ring_next(input logic [RING_W-1:0] pos);
		logic [RING_W-1:0] last;
		last = RING_W'(QUEUE_DEPTH - 1);
		return (pos == last) ? '0 : pos + 1'b1;
	endfunction

endpackage

// ===== src/periodic_timer_bank_event_queue_unit.sv =====
// Top level of the periodic timer bank with event ring.
//
// One command request is taken at a time. A pop that finds an event goes
// through the extra ring read state, ST_POPRD, before it finishes. A tick
// walks the period and count memories one slot per cycle, reading one slot
// while the slot read before it is updated and written back. Every
// other request, a pop on an empty ring included, goes from execution
// straight to the finish state.
// Flag-mode timers raise their pending bit when they fire; queue-mode timers
// push their id into the event ring, which holds QUEUE_DEPTH-1 events and
// drops any push that finds it full. A finished response sits in an output
// register, so the next request is taken while the previous response still
// waits; that request's own response then waits until the output register
// is handed over, that is, while rsp_stall holds the previous response.
module periodic_timer_bank_event_queue_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  logic [ptbq_pkg::KIND_W-1:0]    kind,
	input  logic [ptbq_pkg::ID_W-1:0]      target_id,
	input  logic [ptbq_pkg::PERIOD_W-1:0]  period,
	input  logic                           flag_mode,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic                           status,
	output logic [ptbq_pkg::ID_W-1:0]      result_id
);
	import ptbq_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_WALK   = 3'd2;
	localparam logic [2:0] ST_POPRD  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]          state_q;
	logic [KIND_W-1:0]   kind_q;
	logic [ID_W-1:0]     id_q;
	logic [PERIOD_W-1:0] period_q;
	logic                fmode_q;
	logic                res_status_q;
	logic [ID_W-1:0]     res_id_q;
	logic                rsp_valid_q;
	logic                rsp_status_q;
	logic [ID_W-1:0]     rsp_id_q;
	logic [WALK_W-1:0]   walk_idx_q;
	logic [SLOT_W-1:0]   slot_s1;

	// Per-slot flags
	logic [TIMERS-1:0] used_q;
	logic [TIMERS-1:0] active_q;
	logic [TIMERS-1:0] flag_q;
	logic [TIMERS-1:0] pending_q;

	// Period and count memories
	logic [PERIOD_W-1:0] period_mem [TIMERS];
	logic [PERIOD_W-1:0] count_mem  [TIMERS];
	logic [PERIOD_W-1:0] period_rd_s1;
	logic [PERIOD_W-1:0] count_rd_s1;
	logic [SLOT_W-1:0]   rd_addr;

	logic                cnt_we;
	logic [SLOT_W-1:0]   cnt_waddr;
	logic [PERIOD_W-1:0] cnt_wdata;
	logic                per_we;
	logic [SLOT_W-1:0]   per_waddr;

	logic              cmd_accept;
	logic              in_exec;
	logic              in_walk;
	logic              id_ok;
	logic [SLOT_W-1:0] id_slot;
	logic              free_found;
	logic [SLOT_W-1:0] free_slot;
	logic              live;
	logic [PERIOD_W-1:0] inc;
	logic              fire;
	logic              walk_last;
	logic              rsp_free;

	ring_ctl_t ring_ctl;
	ring_sts_t ring_sts;

	assign cmd_accept = cmd_valid && !cmd_stall;
	assign cmd_stall  = (state_q != ST_IDLE);
	assign in_exec    = (state_q == ST_EXEC);
	assign in_walk    = (state_q == ST_WALK);
	assign id_ok      = ({1'b0, id_q} < (ID_W + 1)'(TIMERS));
	assign id_slot    = id_q[SLOT_W-1:0];
	assign walk_last  = (walk_idx_q == WALK_W'(TIMERS));
	assign rsp_free   = !rsp_valid_q || !rsp_stall;

	// Lowest unused slot
	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = TIMERS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_slot  = SLOT_W'(i);
			end
		end
	end

	// Tick update for the previously read slot
	always_comb begin
		live = used_q[slot_s1] && active_q[slot_s1];
		inc  = (count_rd_s1 == COUNT_MAX) ? count_rd_s1 : count_rd_s1 + 1'b1;
		fire = in_walk && live && (inc >= period_rd_s1);
	end

	// Memory write ports
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = slot_s1;
		cnt_wdata = '0;
		per_we    = 1'b0;
		per_waddr = id_slot;
		if (in_walk && live) begin
			cnt_we    = 1'b1;
			cnt_wdata = fire ? '0 : inc;
		end else if (in_exec && kind_q == KIND_CREATE && free_found) begin
			cnt_we    = 1'b1;
			cnt_waddr = free_slot;
		end else if (in_exec && kind_q == KIND_START && id_ok && used_q[id_slot]) begin
			cnt_we    = 1'b1;
			cnt_waddr = id_slot;
		end
		if (in_exec && kind_q == KIND_CREATE && free_found) begin
			per_we    = 1'b1;
			per_waddr = free_slot;
		end else if (in_exec && kind_q == KIND_PERIOD && id_ok) begin
			per_we = 1'b1;
		end
	end

	assign rd_addr = in_exec ? '0 : walk_idx_q[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			count_mem[cnt_waddr] <= cnt_wdata;
		end
		if (per_we) begin
			period_mem[per_waddr] <= period_q;
		end
		count_rd_s1  <= count_mem[rd_addr];
		period_rd_s1 <= period_mem[rd_addr];
	end

	// Ring requests
	assign ring_ctl.push    = fire && !flag_q[slot_s1];
	assign ring_ctl.push_id = ID_W'(slot_s1);
	assign ring_ctl.pop     = in_exec && (kind_q == KIND_POP) && !ring_sts.empty;

	ptbq_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.sts    (ring_sts)
	);

	// Command latch (payload, no reset)
	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			kind_q   <= kind;
			id_q     <= target_id;
			period_q <= period;
			fmode_q  <= flag_mode;
		end
	end

	// Sequencer and slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= '0;
			active_q     <= '0;
			flag_q       <= '0;
			pending_q    <= '0;
			walk_idx_q   <= '0;
			slot_s1      <= '0;
			res_status_q <= STATUS_FAIL;
			res_id_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (kind_q)
						KIND_TICK: begin
							res_status_q <= STATUS_OK;
							res_id_q     <= '0;
							slot_s1      <= '0;
							walk_idx_q   <= WALK_W'(1);
							state_q      <= ST_WALK;
						end
						KIND_CREATE: begin
							res_status_q <= free_found ? STATUS_OK : STATUS_FAIL;
							res_id_q     <= free_found ? ID_W'(free_slot) : '0;
							state_q      <= ST_FINISH;
							if (free_found) begin
								used_q[free_slot]    <= 1'b1;
								active_q[free_slot]  <= 1'b0;
								flag_q[free_slot]    <= fmode_q;
								pending_q[free_slot] <= 1'b0;
							end
						end
						KIND_START: begin
							res_id_q <= '0;
							state_q  <= ST_FINISH;
							if (id_ok && used_q[id_slot]) begin
								active_q[id_slot]  <= 1'b1;
								pending_q[id_slot] <= 1'b0;
								res_status_q       <= STATUS_OK;
							end else begin
								res_status_q <= STATUS_FAIL;
							end
						end
						KIND_STOP: begin
							res_id_q <= '0;
							state_q  <= ST_FINISH;
							if (id_ok) begin
								active_q[id_slot]  <= 1'b0;
								pending_q[id_slot] <= 1'b0;
								res_status_q       <= STATUS_OK;
							end else begin
								res_status_q <= STATUS_FAIL;
							end
						end
						KIND_PERIOD: begin
							res_id_q     <= '0;
							state_q      <= ST_FINISH;
							res_status_q <= id_ok ? STATUS_OK : STATUS_FAIL;
						end
						KIND_POP: begin
							res_id_q <= '0;
							if (!ring_sts.empty) begin
								res_status_q <= STATUS_OK;
								state_q      <= ST_POPRD;
							end else begin
								res_status_q <= STATUS_FAIL;
								state_q      <= ST_FINISH;
							end
						end
						KIND_TAKE: begin
							res_id_q <= '0;
							state_q  <= ST_FINISH;
							if (id_ok && pending_q[id_slot]) begin
								pending_q[id_slot] <= 1'b0;
								res_status_q       <= STATUS_OK;
							end else begin
								res_status_q <= STATUS_FAIL;
							end
						end
						default: begin
							res_status_q <= STATUS_FAIL;
							res_id_q     <= '0;
							state_q      <= ST_FINISH;
						end
					endcase
				end
				ST_WALK: begin
					if (fire && flag_q[slot_s1]) begin
						pending_q[slot_s1] <= 1'b1;
					end
					if (walk_last) begin
						state_q <= ST_FINISH;
					end else begin
						slot_s1    <= walk_idx_q[SLOT_W-1:0];
						walk_idx_q <= walk_idx_q + 1'b1;
					end
				end
				ST_POPRD: begin
					res_id_q <= ring_sts.rd_data;
					state_q  <= ST_FINISH;
				end
				ST_FINISH: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Response output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= STATUS_FAIL;
			rsp_id_q     <= '0;
		end else if (state_q == ST_FINISH && rsp_free) begin
			rsp_valid_q  <= 1'b1;
			rsp_status_q <= res_status_q;
			rsp_id_q     <= res_id_q;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = rsp_status_q;
	assign result_id = rsp_id_q;

`ifndef SYNTHESIS
	// An accepted request is always executed on the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_accept |=> state_q == ST_EXEC)
		else $error("accepted request not executed");

	// The slot walk never runs past the last timer
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_walk |-> walk_idx_q <= WALK_W'(TIMERS))
		else $error("slot walk out of range");

	// Pushes happen only during a walk, pops only outside it
	a_ring_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ring_ctl.push && ring_ctl.pop))
		else $error("ring push and pop in one cycle");

	// A finished result is handed over once the output register is free
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && rsp_free) |=> rsp_valid_q && state_q == ST_IDLE)
		else $error("finished result not delivered");

	// A pop result is only produced from a non-empty ring
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POPRD |-> res_status_q == STATUS_OK)
		else $error("pop read without an event");
`endif

endmodule

// ===== src/ptbq_ring.sv =====
// Event ring: a small synchronous memory with head and tail pointers.
module ptbq_ring (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptbq_pkg::ring_ctl_t  ctl,
	output ptbq_pkg::ring_sts_t  sts
);
	import ptbq_pkg::*;

	logic [ID_W-1:0]   ring_mem [QUEUE_DEPTH];
	logic [RING_W-1:0] head_q;
	logic [RING_W-1:0] tail_q;
	logic [ID_W-1:0]   rd_q;
	logic              full;
	logic              empty;

	assign empty = (head_q == tail_q);
	assign full  = (ring_next(tail_q) == head_q);

	// Pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (ctl.push && !full) begin
				tail_q <= ring_next(tail_q);
			end
			if (ctl.pop && !empty) begin
				head_q <= ring_next(head_q);
			end
		end
	end

	// Storage; a push that finds the ring full is dropped
	always_ff @(posedge clk) begin
		if (ctl.push && !full) begin
			ring_mem[tail_q] <= ctl.push_id;
		end
		if (ctl.pop) begin
			rd_q <= ring_mem[head_q];
		end
	end

	assign sts.empty   = empty;
	assign sts.rd_data = rd_q;

endmodule

// ===== bench/tb_periodic_timer_bank_event_queue_unit.sv =====
// Self-checking testbench for the periodic timer bank with event ring.
module tb_periodic_timer_bank_event_queue_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ptbq_pkg::*;

	// Kind code with no command behind it
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd7;
	localparam int RANDOM_REQUESTS = 900;
	localparam int REPORT_LIMIT    = 10;

	typedef struct {
		logic [KIND_W-1:0]   op;
		logic [ID_W-1:0]     tid;
		logic [PERIOD_W-1:0] per;
		logic                fmode;
		bit                  drain;	// hold this request until all responses are back
	} req_t;

	typedef struct {
		logic            status;
		logic [ID_W-1:0] rid;
	} rsp_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	logic [KIND_W-1:0]   kind      = '0;
	logic [ID_W-1:0]     target_id = '0;
	logic [PERIOD_W-1:0] period    = '0;
	logic                flag_mode = 1'b0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic                status;
	logic [ID_W-1:0]     result_id;

	periodic_timer_bank_event_queue_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.kind      (kind),
		.target_id (target_id),
		.period    (period),
		.flag_mode (flag_mode),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.result_id (result_id)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Timer bank shadow state
	logic                tmr_used   [TIMERS];
	logic                tmr_active [TIMERS];
	logic                tmr_flag   [TIMERS];
	logic                tmr_pend   [TIMERS];
	logic [PERIOD_W-1:0] tmr_period [TIMERS];
	logic [PERIOD_W-1:0] tmr_count  [TIMERS];
	logic [ID_W-1:0]     event_fifo [$];

	req_t req_backlog [$];
	rsp_t rsp_due [$];
	req_t on_bus;
	int   gap_left   = 0;
	int   stall_left = 0;
	logic quiet      = 1'b0;
	int   errors     = 0;
	int   n_sent     = 0;
	int   n_ticks    = 0;
	int   n_fires    = 0;
	int   n_drops    = 0;
	int   n_popped   = 0;
	int   n_taken    = 0;
	int   n_created  = 0;

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("%s", msg);
	endfunction

	// One tick: walk slots in ascending order, fire on count reaching period
	function automatic void advance_timers();
		for (int i = 0; i < TIMERS; i++) begin
			if (tmr_used[i] && tmr_active[i]) begin
				if (tmr_count[i] < COUNT_MAX)
					tmr_count[i] = tmr_count[i] + 1'b1;
				if (tmr_count[i] >= tmr_period[i]) begin
					tmr_count[i] = '0;
					n_fires++;
					if (tmr_flag[i])
						tmr_pend[i] = 1'b1;
					else if (event_fifo.size() < QUEUE_DEPTH - 1)
						event_fifo.push_back(ID_W'(i));
					else
						n_drops++;
				end
			end
		end
	endfunction

	// Apply one accepted request to the shadow state, return its response
	function automatic rsp_t apply_command(req_t r);
		rsp_t o;
		bit   id_ok;
		bit   found;
		o.status = STATUS_FAIL;
		o.rid    = '0;
		id_ok    = (r.tid < TIMERS);
		found    = 1'b0;
		case (r.op)
			KIND_TICK: begin
				advance_timers();
				n_ticks++;
				o.status = STATUS_OK;
			end
			KIND_CREATE: begin
				for (int i = 0; i < TIMERS; i++) begin
					if (!found && !tmr_used[i]) begin
						found         = 1'b1;
						tmr_used[i]   = 1'b1;
						tmr_period[i] = r.per;
						tmr_count[i]  = '0;
						tmr_active[i] = 1'b0;
						tmr_flag[i]   = r.fmode;
						tmr_pend[i]   = 1'b0;
						o.status      = STATUS_OK;
						o.rid         = ID_W'(i);
						n_created++;
					end
				end
			end
			KIND_START: begin
				if (id_ok && tmr_used[r.tid]) begin
					tmr_count[r.tid]  = '0;
					tmr_pend[r.tid]   = 1'b0;
					tmr_active[r.tid] = 1'b1;
					o.status          = STATUS_OK;
				end
			end
			KIND_STOP: begin
				if (id_ok) begin
					tmr_active[r.tid] = 1'b0;
					tmr_pend[r.tid]   = 1'b0;
					o.status          = STATUS_OK;
				end
			end
			KIND_PERIOD: begin
				if (id_ok) begin
					tmr_period[r.tid] = r.per;
					o.status          = STATUS_OK;
				end
			end
			KIND_POP: begin
				if (event_fifo.size() != 0) begin
					o.rid    = event_fifo.pop_front();
					o.status = STATUS_OK;
					n_popped++;
				end
			end
			KIND_TAKE: begin
				if (id_ok && tmr_pend[r.tid]) begin
					tmr_pend[r.tid] = 1'b0;
					o.status        = STATUS_OK;
					n_taken++;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic req_t make_req(logic [KIND_W-1:0] op, int tid, int per, int fmode);
		req_t r;
		r.op    = op;
		r.tid   = ID_W'(tid);
		r.per   = PERIOD_W'(per);
		r.fmode = 1'(fmode);
		r.drain = 1'b0;
		return r;
	endfunction

	// Tick-heavy command mix; mostly valid ids and short periods so timers fire
	function automatic req_t random_req();
		req_t r;
		int   pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			r.op = KIND_TICK;
		else if (pick < 35)
			r.op = KIND_CREATE;
		else if (pick < 47)
			r.op = KIND_START;
		else if (pick < 55)
			r.op = KIND_STOP;
		else if (pick < 67)
			r.op = KIND_PERIOD;
		else if (pick < 85)
			r.op = KIND_POP;
		else if (pick < 97)
			r.op = KIND_TAKE;
		else
			r.op = KIND_UNKNOWN;
		if ($urandom_range(0, 9) == 0)
			r.tid = ID_W'($urandom_range(TIMERS, 15));
		else
			r.tid = ID_W'($urandom_range(0, TIMERS - 1));
		case ($urandom_range(0, 9))
			0:       r.per = PERIOD_W'($urandom);
			1, 2, 3: r.per = PERIOD_W'($urandom_range(0, 40));
			default: r.per = PERIOD_W'($urandom_range(0, 8));
		endcase
		r.fmode = 1'($urandom_range(0, 1));
		r.drain = 1'b0;
		return r;
	endfunction

	// Request driver: presents backlog entries, applies each accepted one to the shadow
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			quiet     <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				rsp_due.push_back(apply_command(on_bus));
				n_sent++;
				if (!quiet && $urandom_range(0, 3) == 0)
					gap_left = $urandom_range(1, 15);
			end
			quiet <= (req_backlog.size() < 100);
			if (!cmd_valid || !cmd_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (req_backlog.size() != 0 &&
						!(req_backlog[0].drain && rsp_due.size() != 0)) begin
					on_bus = req_backlog.pop_front();
					cmd_valid <= 1'b1;
					kind      <= on_bus.op;
					target_id <= on_bus.tid;
					period    <= on_bus.per;
					flag_mode <= on_bus.fmode;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor with random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (rsp_due.size() == 0) begin
					flag_error($sformatf("unexpected response: status %0d id %0d",
						status, result_id));
				end else begin
					rsp_t e;
					e = rsp_due.pop_front();
					if (status !== e.status)
						flag_error($sformatf("status mismatch: expected %0d, got %0d",
							e.status, status));
					if (result_id !== e.rid)
						flag_error($sformatf("result_id mismatch: expected %0d, got %0d",
							e.rid, result_id));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 14);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		req_t r;
		for (int i = 0; i < TIMERS; i++) begin
			tmr_used[i]   = 1'b0;
			tmr_active[i] = 1'b0;
			tmr_flag[i]   = 1'b0;
			tmr_pend[i]   = 1'b0;
			tmr_period[i] = '0;
			tmr_count[i]  = '0;
		end

		// Empty bank: pop on empty ring, nothing pending, unused slots
		req_backlog.push_back(make_req(KIND_POP, 0, 0, 0));
		req_backlog.push_back(make_req(KIND_TAKE, 0, 0, 0));
		req_backlog.push_back(make_req(KIND_START, 2, 0, 0));
		req_backlog.push_back(make_req(KIND_STOP, 5, 0, 0));
		req_backlog.push_back(make_req(KIND_PERIOD, 6, 16'hFFFF, 0));
		// Out-of-range ids and the unknown kind
		req_backlog.push_back(make_req(KIND_START, 8, 0, 1));
		req_backlog.push_back(make_req(KIND_STOP, 15, 16'hFFFF, 1));
		req_backlog.push_back(make_req(KIND_PERIOD, 9, 16'h5A5A, 0));
		req_backlog.push_back(make_req(KIND_TAKE, 12, 0, 0));
		req_backlog.push_back(make_req(KIND_UNKNOWN, 15, 16'hFFFF, 1));
		// Fill every slot with both modes and extreme periods, then one too many
		req_backlog.push_back(make_req(KIND_CREATE, 0, 0, 0));
		req_backlog.push_back(make_req(KIND_CREATE, 0, 0, 1));
		req_backlog.push_back(make_req(KIND_CREATE, 0, 1, 0));
		req_backlog.push_back(make_req(KIND_CREATE, 0, 2, 1));
		req_backlog.push_back(make_req(KIND_CREATE, 0, 16'hFFFF, 0));
		req_backlog.push_back(make_req(KIND_CREATE, 0, 3, 0));
		req_backlog.push_back(make_req(KIND_CREATE, 0, 0, 0));
		req_backlog.push_back(make_req(KIND_CREATE, 0, 5, 1));
		req_backlog.push_back(make_req(KIND_CREATE, 0, 7, 1));
		// Period-zero timers fire on the first tick
		req_backlog.push_back(make_req(KIND_START, 0, 0, 0));
		req_backlog.push_back(make_req(KIND_START, 1, 0, 0));
		req_backlog.push_back(make_req(KIND_START, 6, 0, 0));
		req_backlog.push_back(make_req(KIND_TICK, 0, 0, 0));
		req_backlog.push_back(make_req(KIND_POP, 0, 0, 0));
		req_backlog.push_back(make_req(KIND_POP, 0, 0, 0));
		req_backlog.push_back(make_req(KIND_TAKE, 1, 0, 0));
		req_backlog.push_back(make_req(KIND_TAKE, 1, 0, 0));

		// Random part, with a few points where the sender drains first
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			r = random_req();
			if (i == 0 || i % 300 == 150)
				r.drain = 1'b1;
			req_backlog.push_back(r);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || cmd_valid || rsp_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (rsp_due.size() != 0)
			flag_error($sformatf("%0d responses never arrived", rsp_due.size()));

		$display("Ran %0d requests: %0d ticks, %0d timer fires, %0d ring drops,",
			n_sent, n_ticks, n_fires, n_drops);
		$display("%0d timers created, %0d events popped, %0d pending flags taken, %0d errors",
			n_created, n_popped, n_taken, errors);
		if (errors == 0)
			$display("tb_periodic_timer_bank_event_queue_unit: PASS");
		else
			$display("tb_periodic_timer_bank_event_queue_unit: FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#400_000;
		$display("tb_periodic_timer_bank_event_queue_unit: FAIL");
		$finish;
	end

endmodule
